// ===== hw/rtl/st3beq_pkg.sv =====
// ----------------------------------------------------------------------------
// st3beq_pkg: shared types and constants of the stereo three-band equaliser
// Holds the field widths, register indexes and reset values, the
// configuration record and the issue schedule of the shared multiplier.
// ----------------------------------------------------------------------------
package st3beq_pkg;

  // Field widths and fixed-point formats
  localparam int SAMPLE_BITS = 24;               // Q1.23 samples
  localparam int COEF_BITS   = 18;
  localparam int POLE_FRAC   = COEF_BITS - 1;    // poles are Q0.17
  localparam int GAIN_FRAC   = COEF_BITS - 4;    // gains are Q4.14
  localparam int POLE_W      = POLE_FRAC;
  localparam int GAIN_W      = COEF_BITS;
  localparam int CFG_W       = GAIN_W;
  localparam int CFG_IDX_W   = 3;
  localparam int ITEM_W      = 4 * SAMPLE_BITS;  // in_l, in_r, prior_l, prior_r
  localparam int OUT_TDATA_W = 2 * SAMPLE_BITS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_POLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_POLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_MODE    = 3'd6;

  // Register reset values
  localparam logic [POLE_W-1:0] RST_LOW_POLE  = 17'd127390;
  localparam logic [POLE_W-1:0] RST_HIGH_POLE = 17'd98575;
  localparam logic [GAIN_W-1:0] RST_GAIN      = 18'd16384;   // unity

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_LVL_W = 2;

  // Back-end sequencer
  localparam int                STEP_W          = 5;
  localparam int                SCHED_LAST      = 16;
  localparam logic [STEP_W-1:0] STEP_LAST_ISSUE = 5'd16;
  localparam logic [STEP_W-1:0] STEP_DONE       = 5'd19;

  localparam logic CH_L = 1'b0;
  localparam logic CH_R = 1'b1;

  // Multiplier operand A sources
  localparam logic [2:0] A_XS   = 3'd0;   // input sample in state format
  localparam logic [2:0] A_LO   = 3'd1;   // low filter state
  localparam logic [2:0] A_HI   = 3'd2;   // high filter state
  localparam logic [2:0] A_MID  = 3'd3;   // mid band
  localparam logic [2:0] A_HIGH = 3'd4;   // high band
  localparam logic [2:0] A_MIX  = 3'd5;   // band mix

  // Multiplier operand B sources
  localparam logic [2:0] B_ALO = 3'd0;    // 1 - low pole
  localparam logic [2:0] B_PLO = 3'd1;    // low pole
  localparam logic [2:0] B_AHI = 3'd2;    // 1 - high pole
  localparam logic [2:0] B_PHI = 3'd3;    // high pole
  localparam logic [2:0] B_GL  = 3'd4;
  localparam logic [2:0] B_GM  = 3'd5;
  localparam logic [2:0] B_GH  = 3'd6;
  localparam logic [2:0] B_GO  = 3'd7;

  // Accumulation chain destinations
  localparam logic [1:0] D_LO  = 2'd0;
  localparam logic [1:0] D_HI  = 2'd1;
  localparam logic [1:0] D_MIX = 2'd2;
  localparam logic [1:0] D_Y   = 2'd3;

  typedef struct packed {
    logic [POLE_W-1:0] low_pole;
    logic [POLE_W-1:0] high_pole;
    logic [GAIN_W-1:0] low_gain;
    logic [GAIN_W-1:0] mid_gain;
    logic [GAIN_W-1:0] high_gain;
    logic [GAIN_W-1:0] master_gain;
    logic              acc_mode;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic       ch;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       first;
    logic       last;
    logic [1:0] dst;
  } issue_t;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
  } back_stat_t;

  localparam issue_t ISSUE_IDLE = '{1'b0, CH_L, A_XS, B_ALO, 1'b0, 1'b0, D_LO};

  // At most one multiply per step. Each chain's result passes the product
  // register and the accumulator before it is written back and usable.
  localparam issue_t SCHED [0:SCHED_LAST] = '{
    '{1'b1, CH_L, A_XS,   B_ALO, 1'b1, 1'b0, D_LO},
    '{1'b1, CH_L, A_LO,   B_PLO, 1'b0, 1'b1, D_LO},
    '{1'b1, CH_L, A_XS,   B_AHI, 1'b1, 1'b0, D_HI},
    '{1'b1, CH_L, A_HI,   B_PHI, 1'b0, 1'b1, D_HI},
    '{1'b1, CH_R, A_XS,   B_ALO, 1'b1, 1'b0, D_LO},
    '{1'b1, CH_R, A_LO,   B_PLO, 1'b0, 1'b1, D_LO},
    '{1'b1, CH_R, A_XS,   B_AHI, 1'b1, 1'b0, D_HI},
    '{1'b1, CH_R, A_HI,   B_PHI, 1'b0, 1'b1, D_HI},
    '{1'b1, CH_L, A_LO,   B_GL,  1'b1, 1'b0, D_MIX},
    '{1'b1, CH_L, A_MID,  B_GM,  1'b0, 1'b0, D_MIX},
    '{1'b1, CH_L, A_HIGH, B_GH,  1'b0, 1'b1, D_MIX},
    '{1'b1, CH_R, A_LO,   B_GL,  1'b1, 1'b0, D_MIX},
    '{1'b1, CH_R, A_MID,  B_GM,  1'b0, 1'b0, D_MIX},
    '{1'b1, CH_R, A_HIGH, B_GH,  1'b0, 1'b1, D_MIX},
    '{1'b1, CH_L, A_MIX,  B_GO,  1'b1, 1'b1, D_Y},
    ISSUE_IDLE,
    '{1'b1, CH_R, A_MIX,  B_GO,  1'b1, 1'b1, D_Y}
  };

endpackage

// ===== hw/rtl/st3beq_front.sv =====
// ----------------------------------------------------------------------------
// st3beq_front: input stage of the equaliser
// Takes input transactions into a register, drops the prior samples in
// replace mode and offers the item to the queue.
// ----------------------------------------------------------------------------
module st3beq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc_mode,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [st3beq_pkg::ITEM_W-1:0]  in_tdata,
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [st3beq_pkg::ITEM_W-1:0]  push_data
);

  localparam int SB = st3beq_pkg::SAMPLE_BITS;

  logic                          vld_r;
  logic                          vld_nxt;
  logic [st3beq_pkg::ITEM_W-1:0] item_r;
  logic                          take;
  logic [SB-1:0]                 prior_l;
  logic [SB-1:0]                 prior_r;

  assign in_tready = !vld_r || push_ready;
  assign take      = in_tvalid && in_tready;

  // In replace mode the prior samples contribute nothing.
  assign prior_l = acc_mode ? in_tdata[2*SB +: SB] : '0;
  assign prior_r = acc_mode ? in_tdata[3*SB +: SB] : '0;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= {prior_r, prior_l, in_tdata[0 +: 2*SB]};
    end
  end

  assign push_valid = vld_r;
  assign push_data  = item_r;

endmodule

// ===== hw/rtl/st3beq_queue.sv =====
// ----------------------------------------------------------------------------
// st3beq_queue: short item queue between front and back
// A small first-in first-out store that lets the input and the arithmetic
// stall independently.
// ----------------------------------------------------------------------------
module st3beq_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push_valid,
  output logic                                push_ready,
  input  logic [st3beq_pkg::ITEM_W-1:0]       push_data,
  output logic                                pop_valid,
  input  logic                                pop,
  output logic [st3beq_pkg::ITEM_W-1:0]       pop_data,
  output logic [st3beq_pkg::Q_LVL_W-1:0]      level
);

  localparam int                        PW   = st3beq_pkg::Q_PTR_W;
  localparam int                        LW   = st3beq_pkg::Q_LVL_W;
  localparam logic [PW-1:0]             PTR_LAST = PW'(st3beq_pkg::Q_DEPTH - 1);
  localparam logic [LW-1:0]             FULL = LW'(st3beq_pkg::Q_DEPTH);

  logic [st3beq_pkg::ITEM_W-1:0] mem_r [st3beq_pkg::Q_DEPTH];
  logic [PW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]                 lvl_r, lvl_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (lvl_r != FULL);
  assign pop_valid  = (lvl_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];
  assign level      = lvl_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    lvl_nxt    = lvl_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_nxt = lvl_r + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_nxt = lvl_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      lvl_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      lvl_r    <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/st3beq_back.sv =====
// ----------------------------------------------------------------------------
// st3beq_back: arithmetic back end of the equaliser
// Runs both channels of one item through a single shared multiplier and
// accumulator under a fixed schedule, and holds the result for output.
// ----------------------------------------------------------------------------
module st3beq_back #(
  parameter int STATE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  st3beq_pkg::cfg_t                     cfg,
  input  logic                                 q_valid,
  input  logic [st3beq_pkg::ITEM_W-1:0]        q_data,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [st3beq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [0:0]                           out_tuser,
  output st3beq_pkg::back_stat_t               stat
);

  localparam int SB      = st3beq_pkg::SAMPLE_BITS;
  localparam int CB      = st3beq_pkg::COEF_BITS;
  localparam int PF      = st3beq_pkg::POLE_FRAC;
  localparam int GF      = st3beq_pkg::GAIN_FRAC;
  localparam int SW      = st3beq_pkg::STEP_W;
  localparam int XF      = STATE_BITS - SB;
  localparam int BAND_W  = STATE_BITS + 1;          // high and mid bands
  localparam int MA      = STATE_BITS + 7;          // widest A operand: the mix
  localparam int PROD_W  = MA + CB + 1;
  localparam int ACC_W   = PROD_W;
  localparam int FV_W    = ACC_W - PF;
  localparam int Y_SHIFT = GF + XF;
  localparam int YS_W    = ACC_W - Y_SHIFT;
  localparam int YW      = YS_W + 1;

  localparam logic [CB-1:0]         POLE_ONE = CB'(1) << PF;
  localparam logic [ACC_W-1:0]      RND_POLE = ACC_W'(1) << (PF - 1);
  localparam logic [ACC_W-1:0]      RND_MIX  = ACC_W'(1) << (GF - 1);
  localparam logic [ACC_W-1:0]      RND_Y    = ACC_W'(1) << (Y_SHIFT - 1);
  localparam logic [STATE_BITS-1:0] ST_MAX   = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic [STATE_BITS-1:0] ST_MIN   = {1'b1, {(STATE_BITS-1){1'b0}}};
  localparam logic [SB-1:0]         SMP_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]         SMP_MIN  = {1'b1, {(SB-1){1'b0}}};

  // Sequencer
  logic          busy_r, busy_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          done;
  st3beq_pkg::issue_t cur;

  // Item and channel state
  logic signed [SB-1:0]         x_l_r, x_r_r, pr_l_r, pr_r_r;
  logic signed [STATE_BITS-1:0] xs_l, xs_r;
  logic signed [STATE_BITS-1:0] lo_l_r, lo_r_r, hi_l_r, hi_r_r;
  logic signed [BAND_W-1:0]     mid_l_r, mid_r_r, high_l_r, high_r_r;
  logic signed [MA-1:0]         mix_l_r, mix_r_r;
  logic signed [SB-1:0]         y_l_r, y_r_r;
  logic                         clip_r;

  // Multiply and accumulate pipeline
  logic signed [MA-1:0]     a_op;
  logic [CB-1:0]            b_op;
  logic signed [CB:0]       b_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     p1_en_r, p1_first_r, p1_last_r, p1_ch_r;
  logic [1:0]               p1_dst_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_base;
  logic                     p2_en_r, p2_last_r, p2_ch_r;
  logic [1:0]               p2_dst_r;
  logic                     wb;

  // Write-back arithmetic
  logic signed [FV_W-1:0]       fv;
  logic [FV_W-STATE_BITS:0]     f_top;
  logic signed [STATE_BITS-1:0] f_sat;
  logic signed [YS_W-1:0]       ys;
  logic signed [YW-1:0]         ysum;
  logic [YW-SB:0]               y_top;
  logic                         y_ok;
  logic signed [SB-1:0]         y_sat;

  // Output register
  logic          out_vld_r, out_vld_nxt;
  logic [SB-1:0] out_l_r, out_r_r;
  logic          out_clip_r;

  // ---------------------------------------------------------------- control
  assign q_pop = !busy_r && q_valid;
  assign done  = busy_r && (step_r == st3beq_pkg::STEP_DONE)
                 && (!out_vld_r || out_tready);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && step_r != st3beq_pkg::STEP_DONE) begin
      step_nxt = step_r + 1'b1;
    end
  end

  assign out_vld_nxt = done ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      step_r    <= '0;
      out_vld_r <= 1'b0;
      p1_en_r   <= 1'b0;
      p2_en_r   <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      step_r    <= step_nxt;
      out_vld_r <= out_vld_nxt;
      p1_en_r   <= cur.en;
      p2_en_r   <= p1_en_r;
    end
  end

  assign cur = (busy_r && step_r <= st3beq_pkg::STEP_LAST_ISSUE)
               ? st3beq_pkg::SCHED[step_r] : st3beq_pkg::ISSUE_IDLE;

  // --------------------------------------------------------------- operands
  assign xs_l = STATE_BITS'(x_l_r) <<< XF;
  assign xs_r = STATE_BITS'(x_r_r) <<< XF;

  always_comb begin
    case (cur.a_sel)
      st3beq_pkg::A_XS:   a_op = MA'(cur.ch ? xs_r : xs_l);
      st3beq_pkg::A_LO:   a_op = MA'(cur.ch ? lo_r_r : lo_l_r);
      st3beq_pkg::A_HI:   a_op = MA'(cur.ch ? hi_r_r : hi_l_r);
      st3beq_pkg::A_MID:  a_op = MA'(cur.ch ? mid_r_r : mid_l_r);
      st3beq_pkg::A_HIGH: a_op = MA'(cur.ch ? high_r_r : high_l_r);
      st3beq_pkg::A_MIX:  a_op = cur.ch ? mix_r_r : mix_l_r;
      default:            a_op = '0;
    endcase
  end

  always_comb begin
    case (cur.b_sel)
      st3beq_pkg::B_ALO: b_op = POLE_ONE - CB'(cfg.low_pole);
      st3beq_pkg::B_PLO: b_op = CB'(cfg.low_pole);
      st3beq_pkg::B_AHI: b_op = POLE_ONE - CB'(cfg.high_pole);
      st3beq_pkg::B_PHI: b_op = CB'(cfg.high_pole);
      st3beq_pkg::B_GL:  b_op = cfg.low_gain;
      st3beq_pkg::B_GM:  b_op = cfg.mid_gain;
      st3beq_pkg::B_GH:  b_op = cfg.high_gain;
      st3beq_pkg::B_GO:  b_op = cfg.master_gain;
      default:           b_op = '0;
    endcase
  end

  assign b_s      = $signed({1'b0, b_op});
  assign prod_nxt = a_op * b_s;

  // ------------------------------------------------------ multiply pipeline
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    p1_first_r <= cur.first;
    p1_last_r  <= cur.last;
    p1_ch_r    <= cur.ch;
    p1_dst_r   <= cur.dst;
  end

  // The rounding half is folded in with the first term of every chain.
  always_comb begin
    if (p1_first_r) begin
      case (p1_dst_r)
        st3beq_pkg::D_LO,
        st3beq_pkg::D_HI:  acc_base = RND_POLE;
        st3beq_pkg::D_MIX: acc_base = RND_MIX;
        st3beq_pkg::D_Y:   acc_base = RND_Y;
        default:           acc_base = '0;
      endcase
    end else begin
      acc_base = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_en_r) begin
      acc_r <= acc_base + prod_r;
    end
    p2_last_r <= p1_last_r;
    p2_ch_r   <= p1_ch_r;
    p2_dst_r  <= p1_dst_r;
  end

  // -------------------------------------------------------------- write-back
  assign wb = p2_en_r && p2_last_r;

  assign fv    = acc_r[ACC_W-1:PF];
  assign f_top = fv[FV_W-1:STATE_BITS-1];
  assign f_sat = (&f_top || ~|f_top) ? fv[STATE_BITS-1:0]
               : (fv[FV_W-1] ? ST_MIN : ST_MAX);

  assign ys    = acc_r[ACC_W-1:Y_SHIFT];
  assign ysum  = YW'(ys) + YW'(p2_ch_r ? pr_r_r : pr_l_r);
  assign y_top = ysum[YW-1:SB-1];
  assign y_ok  = &y_top || ~|y_top;
  assign y_sat = y_ok ? ysum[SB-1:0] : (ysum[YW-1] ? SMP_MIN : SMP_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_l_r <= '0;
      lo_r_r <= '0;
      hi_l_r <= '0;
      hi_r_r <= '0;
    end else if (wb && p2_dst_r == st3beq_pkg::D_LO) begin
      if (p2_ch_r) begin
        lo_r_r <= f_sat;
      end else begin
        lo_l_r <= f_sat;
      end
    end else if (wb && p2_dst_r == st3beq_pkg::D_HI) begin
      if (p2_ch_r) begin
        hi_r_r <= f_sat;
      end else begin
        hi_l_r <= f_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb && p2_dst_r == st3beq_pkg::D_MIX) begin
      if (p2_ch_r) begin
        mix_r_r <= acc_r[GF +: MA];
      end else begin
        mix_l_r <= acc_r[GF +: MA];
      end
    end
    if (wb && p2_dst_r == st3beq_pkg::D_Y) begin
      if (p2_ch_r) begin
        y_r_r <= y_sat;
      end else begin
        y_l_r <= y_sat;
      end
    end
    if (q_pop) begin
      clip_r <= 1'b0;
    end else if (wb && p2_dst_r == st3beq_pkg::D_Y && !y_ok) begin
      clip_r <= 1'b1;
    end
  end

  // Band values are re-derived every cycle; the schedule reads them only
  // after both filter states of the channel have settled.
  always_ff @(posedge clk) begin
    mid_l_r  <= BAND_W'(hi_l_r) - BAND_W'(lo_l_r);
    mid_r_r  <= BAND_W'(hi_r_r) - BAND_W'(lo_r_r);
    high_l_r <= BAND_W'(xs_l) - BAND_W'(hi_l_r);
    high_r_r <= BAND_W'(xs_r) - BAND_W'(hi_r_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_l_r  <= q_data[0 +: SB];
      x_r_r  <= q_data[SB +: SB];
      pr_l_r <= q_data[2*SB +: SB];
      pr_r_r <= q_data[3*SB +: SB];
    end
  end

  // ------------------------------------------------------------------ output
  always_ff @(posedge clk) begin
    if (done) begin
      out_l_r    <= y_l_r;
      out_r_r    <= y_r_r;
      out_clip_r <= clip_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r_r, out_l_r};
  assign out_tuser  = out_clip_r;
  assign stat       = '{busy: busy_r, step: step_r};

endmodule

// ===== hw/rtl/stereo_three_band_equalizer.sv =====
// ----------------------------------------------------------------------------
// stereo_three_band_equalizer: stereo three-band equaliser, top level
// The back end takes a new stereo pair only after the last one has moved
// to the output register; its sixteen multiplies pass one at a time through
// the single shared multiplier and its two-stage accumulate pipeline. Reset
// (rst_n, synchronous, active low) clears the filter states, the queue and
// all handshakes, and loads the registers with their documented defaults.
// ----------------------------------------------------------------------------
//
// Structure
//   front  - registers each input transaction and, in replace mode, zeroes
//            the prior samples so the back end always adds them.
//   queue  - two-entry queue; the front keeps accepting while the back end
//            is busy or its result waits to be taken.
//   back   - a step counter walks a fixed schedule through one multiplier
//            and one accumulator. Per channel it runs the low and high
//            one-pole filters (two products each), the three-band mix
//            (three products) and the output gain (one product). Rounding
//            is round half up; the filter states and the outputs saturate.
//            The finished pair waits in an output register.
//
// Configuration
//   A write with cfg_we high updates the register named by cfg_index at the
//   next rising edge. Indexes beyond the last register are ignored. Writes
//   are expected only while no transaction is in flight.
module stereo_three_band_equalizer #(
  parameter int STATE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: in_left [23:0], in_right [47:24], prior_left [71:48],
  //           prior_right [95:72]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [st3beq_pkg::ITEM_W-1:0]        in_tdata,
  // out_tdata: out_left [23:0], out_right [47:24]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [st3beq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: clipped [0]
  output logic [0:0]                           out_tuser,
  input  logic                                 cfg_we,
  input  logic [st3beq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [st3beq_pkg::CFG_W-1:0]         cfg_data
);

  localparam int PW = st3beq_pkg::POLE_W;
  localparam int GW = st3beq_pkg::GAIN_W;

  st3beq_pkg::cfg_t cfg_r;

  logic                                 push_valid;
  logic                                 push_ready;
  logic [st3beq_pkg::ITEM_W-1:0]        push_data;
  logic                                 q_valid;
  logic                                 q_pop;
  logic [st3beq_pkg::ITEM_W-1:0]        q_data;
  logic [st3beq_pkg::Q_LVL_W-1:0]       q_level;
  st3beq_pkg::back_stat_t               bk_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_pole    <= st3beq_pkg::RST_LOW_POLE;
      cfg_r.high_pole   <= st3beq_pkg::RST_HIGH_POLE;
      cfg_r.low_gain    <= st3beq_pkg::RST_GAIN;
      cfg_r.mid_gain    <= st3beq_pkg::RST_GAIN;
      cfg_r.high_gain   <= st3beq_pkg::RST_GAIN;
      cfg_r.master_gain <= st3beq_pkg::RST_GAIN;
      cfg_r.acc_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        st3beq_pkg::REG_LOW_POLE:    cfg_r.low_pole    <= cfg_data[PW-1:0];
        st3beq_pkg::REG_HIGH_POLE:   cfg_r.high_pole   <= cfg_data[PW-1:0];
        st3beq_pkg::REG_LOW_GAIN:    cfg_r.low_gain    <= cfg_data[GW-1:0];
        st3beq_pkg::REG_MID_GAIN:    cfg_r.mid_gain    <= cfg_data[GW-1:0];
        st3beq_pkg::REG_HIGH_GAIN:   cfg_r.high_gain   <= cfg_data[GW-1:0];
        st3beq_pkg::REG_MASTER_GAIN: cfg_r.master_gain <= cfg_data[GW-1:0];
        st3beq_pkg::REG_ACC_MODE:    cfg_r.acc_mode    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  st3beq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_mode   (cfg_r.acc_mode),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  st3beq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data),
    .level      (q_level)
  );

  st3beq_back #(
    .STATE_BITS (STATE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (bk_stat)
  );

  // The input side only stalls when the front holds an item and the queue
  // is full.
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_level == st3beq_pkg::Q_LVL_W'(st3beq_pkg::Q_DEPTH)))
    else $error("input stalled while the queue had room");

  // The back end only starts work on an item it has taken from the queue.
  a_start_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bk_stat.busy) |-> $past(q_pop))
    else $error("back end started without taking an item");

  // A finished item with a free output register is presented next cycle.
  a_finish_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.busy && bk_stat.step == st3beq_pkg::STEP_DONE
     && (!out_tvalid || out_tready))
    |=> (out_tvalid && !bk_stat.busy))
    else $error("finished item not moved to the output register");

endmodule

// ===== tb/stereo_three_band_equalizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_three_band_equalizer_test: self-checking bench for the equaliser
// Drives stereo sample transactions into the equaliser and checks every
// result, field by field, against a bit-exact model of the one-pole
// crossovers, the band mix, the output gain and the final saturation. A short
// directed table comes first, then randomised phases, each under fresh
// register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module stereo_three_band_equalizer_test;

  localparam int SAMPLE_BITS = st3beq_pkg::SAMPLE_BITS;
  localparam int CFG_IDX_W   = st3beq_pkg::CFG_IDX_W;
  localparam int CFG_W       = st3beq_pkg::CFG_W;
  localparam int ITEM_W      = st3beq_pkg::ITEM_W;
  localparam int OUT_TDATA_W = st3beq_pkg::OUT_TDATA_W;
  localparam int POLE_W      = st3beq_pkg::POLE_W;
  localparam int POLE_FRAC   = st3beq_pkg::POLE_FRAC;
  localparam int GAIN_FRAC   = st3beq_pkg::GAIN_FRAC;

  // The filter states carry eight more fraction bits than a sample.
  localparam int FILT_BITS = 32;
  localparam int XF_BITS   = FILT_BITS - SAMPLE_BITS;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int S_MAX = 8388607;
  localparam int S_MIN = -8388608;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;         // comfortably above the latency of one item
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;
  typedef enum logic {ROW_ITEM, ROW_WRITE} plan_kind_t;

  // One input transaction; in_left sits in the lowest bits of in_tdata.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] prior_r;
    logic signed [SAMPLE_BITS-1:0] prior_l;
    logic signed [SAMPLE_BITS-1:0] in_r;
    logic signed [SAMPLE_BITS-1:0] in_l;
  } pair_in_t;

  typedef struct packed {
    logic                   clipped;
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] left;
  } eq_out_t;

  // A directed row is either a register write or a sample transaction. Where
  // typed is set, the expected result is written into the row itself.
  typedef struct packed {
    plan_kind_t                    kind;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_W-1:0]              value;
    logic signed [SAMPLE_BITS-1:0] in_l;
    logic signed [SAMPLE_BITS-1:0] in_r;
    logic signed [SAMPLE_BITS-1:0] prior_l;
    logic signed [SAMPLE_BITS-1:0] prior_r;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] want_l;
    logic signed [SAMPLE_BITS-1:0] want_r;
    logic                          want_clip;
  } plan_row_t;

  // With unity gains the three bands sum back to the input exactly, so the
  // opening rows simply expect their input back, whatever the poles are.
  localparam int PLAN_ROWS = 36;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM,  REG_NONE, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MAX, S_MIN, 0, 0, 1, S_MAX, S_MIN, 0},
    // replace mode ignores the prior samples
    '{ROW_ITEM,  REG_NONE, 0, S_MIN, S_MAX, S_MAX, S_MIN, 1, S_MIN, S_MAX, 0},
    '{ROW_ITEM,  REG_NONE, 0, 1, -1, S_MIN, S_MAX, 1, 1, -1, 0},
    '{ROW_ITEM,  REG_NONE, 0, 5592405, -5592406, 0, 0, 1, 5592405, -5592406, 0},
    // accumulate mode: one saturation of output plus prior
    '{ROW_WRITE, st3beq_pkg::REG_ACC_MODE, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MAX, S_MIN, S_MAX, S_MIN, 1, S_MAX, S_MIN, 1},
    '{ROW_ITEM,  REG_NONE, 0, 100, -100, -100, 100, 1, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, 1000, -1000, 8387607, -8387608, 1, S_MAX, S_MIN, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MAX, 0, 1, 0, 1, S_MAX, 0, 1},
    '{ROW_WRITE, st3beq_pkg::REG_ACC_MODE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // zero poles pass the input straight through both filters, leaving only
    // the low band, here doubled
    '{ROW_WRITE, st3beq_pkg::REG_LOW_POLE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_HIGH_POLE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_LOW_GAIN, 32768, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, 1000, -3000, 0, 0, 1, 2000, -6000, 0},
    '{ROW_ITEM,  REG_NONE, 0, 4194304, -4194304, 0, 0, 1, S_MAX, S_MIN, 1},
    // gains far above 8.0 use the whole register
    '{ROW_WRITE, st3beq_pkg::REG_LOW_GAIN, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_MID_GAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_HIGH_GAIN, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_MASTER_GAIN, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, 12345, -54321, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MIN, S_MAX, 0, 0, 0, 0, 0, 0},
    // the pole registers drop the eighteenth bit of the write data
    '{ROW_WRITE, st3beq_pkg::REG_LOW_POLE, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_HIGH_POLE, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_MID_GAIN, 131072, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_MASTER_GAIN, 4096, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MAX, S_MAX, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MIN, S_MIN, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WRITE, REG_NONE, 262143, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, -777, 777, 0, 0, 0, 0, 0, 0},
    // no output gain: the output is zero, or just the prior when accumulating
    '{ROW_WRITE, st3beq_pkg::REG_MASTER_GAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MAX, S_MIN, S_MIN, S_MAX, 1, 0, 0, 0},
    '{ROW_WRITE, st3beq_pkg::REG_ACC_MODE, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_ITEM,  REG_NONE, 0, 5, -7, S_MIN, S_MAX, 1, S_MIN, S_MAX, 0},
    '{ROW_ITEM,  REG_NONE, 0, S_MIN, S_MAX, 1, -1, 1, 1, -1, 0}
  };

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [ITEM_W-1:0]      in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = st3beq_pkg::REG_LOW_POLE;
  logic [CFG_W-1:0]       cfg_data   = '0;

  stereo_three_band_equalizer #(
    .STATE_BITS(FILT_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Equaliser model: its own copy of the registers and the four filter states
  // (index 0 is the left channel, 1 the right).
  // --------------------------------------------------------------------------
  st3beq_pkg::cfg_t eq_cfg;
  longint  low_state [2];
  longint  high_state [2];
  eq_out_t awaited [$];         // expected results, oldest first

  int         n_fail     = 0;
  int         n_results  = 0;
  int         n_clipped  = 0;
  int         n_writes   = 0;
  int         cycles     = 0;
  idle_mode_t in_mode    = IDLE_LIGHT;
  idle_mode_t stall_mode = IDLE_LIGHT;
  int         stall_left = 0;
  eq_out_t    oldest;

  // Round half up: add half an LSB, then an arithmetic (flooring) shift.
  function automatic longint round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint saturate(longint v, int bits, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One-pole lowpass, y = (1 - p) * x + p * y_prev, with p in Q0.17.
  function automatic longint filter_step(longint xs, longint prev, logic [POLE_W-1:0] p);
    longint pl;
    longint acc;
    bit     ignored;
    pl      = longint'(p);
    acc     = ((longint'(1) <<< POLE_FRAC) - pl) * xs + pl * prev;
    ignored = 1'b0;
    return saturate(round_half_up(acc, POLE_FRAC), FILT_BITS, ignored);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] eq_channel(int ch,
                                                        logic signed [SAMPLE_BITS-1:0] x,
                                                        logic signed [SAMPLE_BITS-1:0] prior,
                                                        inout bit clip);
    longint xs;
    longint low_band;
    longint mid_band;
    longint high_band;
    longint mix;
    longint y;
    xs             = longint'(x) * (longint'(1) <<< XF_BITS);
    low_state[ch]  = filter_step(xs, low_state[ch], eq_cfg.low_pole);
    high_state[ch] = filter_step(xs, high_state[ch], eq_cfg.high_pole);
    low_band       = low_state[ch];
    high_band      = xs - high_state[ch];
    mid_band       = xs - low_band - high_band;
    mix = round_half_up(low_band * longint'(eq_cfg.low_gain)
                        + mid_band * longint'(eq_cfg.mid_gain)
                        + high_band * longint'(eq_cfg.high_gain), GAIN_FRAC);
    y = round_half_up(mix * longint'(eq_cfg.master_gain), GAIN_FRAC + XF_BITS);
    if (eq_cfg.acc_mode)
      y = y + longint'(prior);
    y = saturate(y, SAMPLE_BITS, clip);
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Left is worked out before right; both share the clipped flag.
  function automatic eq_out_t predict_pair(pair_in_t d);
    eq_out_t r;
    bit      clip;
    clip      = 1'b0;
    r.left    = eq_channel(0, d.in_l, d.prior_l, clip);
    r.right   = eq_channel(1, d.in_r, d.prior_r, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    case (idx)
      st3beq_pkg::REG_LOW_POLE:    eq_cfg.low_pole    = v[POLE_W-1:0];
      st3beq_pkg::REG_HIGH_POLE:   eq_cfg.high_pole   = v[POLE_W-1:0];
      st3beq_pkg::REG_LOW_GAIN:    eq_cfg.low_gain    = v;
      st3beq_pkg::REG_MID_GAIN:    eq_cfg.mid_gain    = v;
      st3beq_pkg::REG_HIGH_GAIN:   eq_cfg.high_gain   = v;
      st3beq_pkg::REG_MASTER_GAIN: eq_cfg.master_gain = v;
      st3beq_pkg::REG_ACC_MODE:    eq_cfg.acc_mode    = v[0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int idle_len(idle_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == IDLE_NONE)
      return 0;
    if (roll < ((mode == IDLE_LIGHT) ? 75 : 45))
      return 0;
    if (roll < 96)
      return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  // Extremes, silence, small values and slow drifts mixed with full-scale
  // noise; the drifts let the filter states settle to something meaningful.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      logic signed [SAMPLE_BITS-1:0] prev);
    int step;
    step = int'($urandom_range(0, 131071)) - 65536;
    case ($urandom_range(0, 9))
      0:       return SAMPLE_BITS'(S_MAX);
      1:       return SAMPLE_BITS'(S_MIN);
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      3:       return '0;
      4, 5, 6: return SAMPLE_BITS'(int'(prev) + step);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Pole words sometimes carry a stray bit 17, which the register drops.
  function automatic logic [CFG_W-1:0] pick_pole();
    logic [CFG_W-1:0] w;
    case ($urandom_range(0, 5))
      0:       w = '0;
      1:       w = '1;
      2:       w = CFG_W'(st3beq_pkg::RST_LOW_POLE);
      3:       w = CFG_W'(131072 - $urandom_range(1, 4096));
      default: w = CFG_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    logic [CFG_W-1:0] w;
    case ($urandom_range(0, 6))
      0:       w = '0;
      1:       w = '1;
      2:       w = st3beq_pkg::RST_GAIN;
      3:       w = CFG_W'(131072);
      4, 5:    w = CFG_W'($urandom_range(8192, 32768));
      default: w = CFG_W'($urandom);
    endcase
    return w;
  endfunction

  // Offers one transaction after an optional gap and records what it should
  // produce once it has been taken. tvalid stays high on return, so a
  // following transaction with no gap goes out back to back.
  task automatic send_pair(pair_in_t d, int gap, bit typed, eq_out_t want);
    eq_out_t calc;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    // The model runs on every row so its filter states stay in step.
    calc = predict_pair(d);
    awaited.push_back(typed ? want : calc);
  endtask

  // Every transaction yields one result, so once nothing is awaited the
  // equaliser is idle and its registers may be rewritten.
  task automatic wait_for_quiet();
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_write(idx, v);
    n_writes++;
    @(posedge clk);
  endtask

  // Phase 0 puts every register at its minimum, phase 1 at its maximum; the
  // others draw a mix of extremes, unity and random values.
  task automatic load_setting(int ph);
    logic [CFG_W-1:0] lp;
    logic [CFG_W-1:0] hp;
    logic [CFG_W-1:0] gl;
    logic [CFG_W-1:0] gm;
    logic [CFG_W-1:0] gh;
    logic [CFG_W-1:0] go;
    logic [CFG_W-1:0] am;
    if (ph == 0) begin
      {lp, hp, gl, gm, gh, go, am} = '0;
    end else if (ph == 1) begin
      {lp, hp, gl, gm, gh, go, am} = '1;
    end else begin
      lp = pick_pole();
      hp = pick_pole();
      gl = pick_gain();
      gm = pick_gain();
      gh = pick_gain();
      go = pick_gain();
      am = CFG_W'($urandom);
    end
    write_reg(st3beq_pkg::REG_LOW_POLE, lp);
    write_reg(st3beq_pkg::REG_HIGH_POLE, hp);
    write_reg(st3beq_pkg::REG_LOW_GAIN, gl);
    write_reg(st3beq_pkg::REG_MID_GAIN, gm);
    write_reg(st3beq_pkg::REG_HIGH_GAIN, gh);
    write_reg(st3beq_pkg::REG_MASTER_GAIN, go);
    write_reg(st3beq_pkg::REG_ACC_MODE, am);
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_NONE, CFG_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, and a check of every result
  // transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      stall_left = idle_len(stall_mode);
      out_tready <= (stall_left == 0);
      if (stall_left > 0)
        stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser[0])
        n_clipped++;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with nothing awaited: left %0d right %0d clipped %0b",
                 $time, $signed(out_tdata[SAMPLE_BITS-1:0]),
                 $signed(out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]), out_tuser[0]);
        n_fail++;
      end else begin
        oldest = awaited.pop_front();
        if (out_tdata[SAMPLE_BITS-1:0] !== oldest.left) begin
          $display("%0t ns: left sample: expected %0d, got %0d", $time,
                   $signed(oldest.left), $signed(out_tdata[SAMPLE_BITS-1:0]));
          n_fail++;
        end
        if (out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] !== oldest.right) begin
          $display("%0t ns: right sample: expected %0d, got %0d", $time,
                   $signed(oldest.right), $signed(out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
          n_fail++;
        end
        if (out_tuser[0] !== oldest.clipped) begin
          $display("%0t ns: clipped flag: expected %0b, got %0b", $time,
                   oldest.clipped, out_tuser[0]);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, awaited.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pair_in_t                      pair;
    logic signed [SAMPLE_BITS-1:0] drift [4];

    eq_cfg.low_pole    = st3beq_pkg::RST_LOW_POLE;
    eq_cfg.high_pole   = st3beq_pkg::RST_HIGH_POLE;
    eq_cfg.low_gain    = st3beq_pkg::RST_GAIN;
    eq_cfg.mid_gain    = st3beq_pkg::RST_GAIN;
    eq_cfg.high_gain   = st3beq_pkg::RST_GAIN;
    eq_cfg.master_gain = st3beq_pkg::RST_GAIN;
    eq_cfg.acc_mode    = 1'b0;
    low_state          = '{0, 0};
    high_state         = '{0, 0};
    drift              = '{0, 0, 0, 0};

    // Reset is held at the start of the run and never asserted again.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, run under light gaps and stalls.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        wait_for_quiet();
        write_reg(PLAN[r].idx, PLAN[r].value);
      end else begin
        send_pair('{PLAN[r].prior_r, PLAN[r].prior_l, PLAN[r].in_r, PLAN[r].in_l},
                  idle_len(in_mode), PLAN[r].typed,
                  '{PLAN[r].want_clip, PLAN[r].want_r, PLAN[r].want_l});
      end
    end

    // Random phases. The idle modes step through every pairing of sender and
    // receiver behaviour, including stretches with no idling at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_quiet();
      in_mode    = idle_mode_t'(ph % 3);
      stall_mode = idle_mode_t'((ph / 3) % 3);
      load_setting(ph);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        for (int f = 0; f < 4; f++)
          drift[f] = pick_sample(drift[f]);
        pair = '{drift[3], drift[2], drift[1], drift[0]};
        send_pair(pair, idle_len(in_mode), 1'b0, '0);
      end
    end

    // Drain, then linger long enough to catch any stray result.
    wait_for_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d stereo results, %0d of them saturated, across %0d register writes.",
             n_results, n_clipped, n_writes);
    $display("Poles and gains ran from zero to full scale in replace and accumulate modes.");
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", n_fail);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
